### design/assert_macros.svh
// Assertion macros shared by the checker. Each one is clocked on i_clk and
// held off while i_rst_n is low, so it may only be used where both exist.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/slcd_pkg.sv
`default_nettype none
package slcd_pkg;

    localparam int IMAGE_BYTES = 16;
    localparam int IMG_AW      = $clog2(IMAGE_BYTES);

    // Command codes; codes above FUNC_INIT do nothing.
    localparam logic [3:0] FUNC_DIGIT    = 4'd0;
    localparam logic [3:0] FUNC_PAIR     = 4'd1;
    localparam logic [3:0] FUNC_ICON_ON  = 4'd2;
    localparam logic [3:0] FUNC_ICON_OFF = 4'd3;
    localparam logic [3:0] FUNC_ICON_TOG = 4'd4;
    localparam logic [3:0] FUNC_FAN      = 4'd5;
    localparam logic [3:0] FUNC_FLUSH    = 4'd6;
    localparam logic [3:0] FUNC_CLEAR    = 4'd7;
    localparam logic [3:0] FUNC_SET      = 4'd8;
    localparam logic [3:0] FUNC_INIT     = 4'd9;

    localparam logic [2:0] ICON_ALL = 3'd7;

    // Bytes sent to the LCD controller.
    localparam logic [7:0] BYTE_DATA_CMD   = 8'h40;
    localparam logic [7:0] BYTE_ADDR_FLUSH = 8'hC2;
    localparam logic [7:0] BYTE_ADDR_FILL  = 8'hC0;
    localparam logic [7:0] BYTE_DISP_ON    = 8'h97;
    localparam logic [7:0] BYTE_MODE       = 8'h00;
    localparam logic [7:0] BYTE_BLANK      = 8'h00;
    localparam logic [7:0] BYTE_FULL       = 8'hFF;

    // Step numbers of the final byte of each run; STEP_INIT_HEAD is the length of the init head.
    localparam logic [4:0] STEP_FLUSH_LAST = 5'd14;
    localparam logic [4:0] STEP_FILL_LAST  = 5'd17;
    localparam logic [4:0] STEP_INIT_LAST  = 5'd19;
    localparam logic [4:0] STEP_INIT_HEAD  = 5'd2;

    typedef struct packed {
        logic [3:0] func;
        logic [3:0] position;
        logic [7:0] value;
        logic [2:0] icon;
    } t_in_item;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       strobe_end;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_RMW,
        CLS_EMIT
    } t_cls;

    typedef enum logic [1:0] {
        ICOP_SET,
        ICOP_CLR,
        ICOP_TOG
    } t_icop;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_PREP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic wr_en;
        logic next_op;
        logic emit;
        logic next_step;
    } t_dp_cmd;

    typedef struct packed {
        t_cls in_cls;
        logic last_op;
        logic last_byte;
        logic out_room;
    } t_dp_stat;

    function automatic t_cls cmd_class(input logic [3:0] func);
        t_cls c;
        case (func)
            FUNC_DIGIT, FUNC_PAIR, FUNC_ICON_ON, FUNC_ICON_OFF,
            FUNC_ICON_TOG, FUNC_FAN:                            c = CLS_RMW;
            FUNC_FLUSH, FUNC_CLEAR, FUNC_SET, FUNC_INIT:        c = CLS_EMIT;
            default:                                            c = CLS_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [IMG_AW-1:0] digit_slot(input logic [3:0] pos);
        logic [IMG_AW-1:0] s;
        case (pos)
            4'd0:    s = IMG_AW'(10);
            4'd1:    s = IMG_AW'(9);
            4'd2:    s = IMG_AW'(5);
            4'd3:    s = IMG_AW'(4);
            4'd4:    s = IMG_AW'(12);
            4'd5:    s = IMG_AW'(11);
            4'd6:    s = IMG_AW'(2);
            4'd7:    s = IMG_AW'(3);
            4'd8:    s = IMG_AW'(14);
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] seg_a(input logic [3:0] d);
        logic [7:0] b;
        case (d)
            4'd0: b = 8'hAF;  4'd1: b = 8'h06;  4'd2: b = 8'h6D;  4'd3: b = 8'h4F;
            4'd4: b = 8'hC6;  4'd5: b = 8'hCB;  4'd6: b = 8'hEB;  4'd7: b = 8'h0E;
            4'd8: b = 8'hEF;  4'd9: b = 8'hCF;
            default: b = BYTE_BLANK;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] seg_b(input logic [3:0] d);
        logic [7:0] b;
        case (d)
            4'd0: b = 8'hF5;  4'd1: b = 8'h60;  4'd2: b = 8'hB6;  4'd3: b = 8'hF2;
            4'd4: b = 8'h63;  4'd5: b = 8'hD3;  4'd6: b = 8'hD7;  4'd7: b = 8'h70;
            4'd8: b = 8'hF7;  4'd9: b = 8'hF3;
            default: b = BYTE_BLANK;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] seg_c(input logic [3:0] d);
        logic [7:0] b;
        case (d)
            4'd0: b = 8'h5F;  4'd1: b = 8'h06;  4'd2: b = 8'h6B;  4'd3: b = 8'h2F;
            4'd4: b = 8'h36;  4'd5: b = 8'h3D;  4'd6: b = 8'h7D;  4'd7: b = 8'h07;
            4'd8: b = 8'h7F;  4'd9: b = 8'h3F;
            default: b = BYTE_BLANK;
        endcase
        return b;
    endfunction

    function automatic logic [IMG_AW-1:0] icon_slot(input logic [2:0] k);
        logic [IMG_AW-1:0] s;
        case (k)
            3'd0:    s = IMG_AW'(10);
            3'd1:    s = IMG_AW'(9);
            3'd2:    s = IMG_AW'(5);
            3'd3:    s = IMG_AW'(4);
            3'd4:    s = IMG_AW'(2);
            3'd5:    s = IMG_AW'(12);
            3'd6:    s = IMG_AW'(14);
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] icon_mask(input logic [2:0] k);
        logic [7:0] m;
        case (k)
            3'd0, 3'd1, 3'd2, 3'd3: m = 8'h10;
            3'd4:                   m = 8'h08;
            3'd5, 3'd6:             m = 8'h80;
            default:                m = 8'h00;
        endcase
        return m;
    endfunction

    // Fan icons in fan-index order: fan1, fan2, fan3.
    function automatic logic [2:0] fan_icon(input logic [1:0] j);
        logic [2:0] k;
        case (j)
            2'd0:    k = 3'd1;
            2'd1:    k = 3'd3;
            default: k = 3'd6;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

### design/slcd_ctrl.sv
`default_nettype none
module slcd_ctrl import slcd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_stat.in_cls)
                        CLS_RMW:  n_state = S_RD;
                        CLS_EMIT: n_state = S_PREP;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_RD:   n_state = S_WR;
            S_WR:   n_state = i_stat.last_op ? S_IDLE : S_RD;
            S_PREP: n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_room) begin
                    n_state = i_stat.last_byte ? S_IDLE : S_PREP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_RD:   o_cmd.rd_en = 1'b1;
            S_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.next_op = !i_stat.last_op;
            end
            S_PREP: o_cmd.rd_en = 1'b1;
            S_EMIT: begin
                o_cmd.emit      = i_stat.out_room;
                o_cmd.next_step = i_stat.out_room && !i_stat.last_byte;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

### design/slcd_dpath.sv
`default_nettype none
module slcd_dpath import slcd_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_item,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_stat       o_stat,
    input  wire logic      i_out_ready,
    output logic           o_out_valid,
    output t_out_item      o_out_item
);

    // Segment image: one write and one registered read per cycle.
    logic [7:0]             r_mem [IMAGE_BYTES];
    logic [IMAGE_BYTES-1:0] r_vld;
    logic [7:0]             r_rd_data;
    logic                   r_rd_vld;

    t_in_item   r_item, n_item;
    logic [4:0] r_tens, n_tens;
    logic [2:0] r_sub, n_sub;
    logic [4:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out_item, n_out_item;

    logic [15:0]       tens_prod;
    logic [7:0]        rd_eff;
    logic [7:0]        ones_full;
    logic [4:0]        dpos;
    logic [7:0]        num;
    logic [3:0]        dsel;
    logic [7:0]        seg;
    logic [7:0]        keep;
    logic [2:0]        ik;
    logic [7:0]        imask;
    t_icop             iop;
    logic [7:0]        new_byte;
    logic [IMG_AW-1:0] slot;
    logic              wr_ok;
    logic [IMG_AW-1:0] addr;
    logic [2:0]        op_last;
    logic              is_dig;
    logic              is_emit;
    logic [4:0]        eff_step;
    logic [7:0]        fill;
    t_out_item         emit_item;

    assign rd_eff  = r_rd_vld ? r_rd_data : BYTE_BLANK;
    assign is_dig  = (r_item.func == FUNC_DIGIT) || (r_item.func == FUNC_PAIR);
    assign is_emit = (cmd_class(r_item.func) == CLS_EMIT);

    // Tens digit by reciprocal: exact for every 8-bit value.
    assign tens_prod = 16'(i_in_item.value) * 16'd205;
    assign ones_full = r_item.value - {r_tens, 3'b000} - {2'b00, r_tens, 1'b0};

    // Read-modify-write of one image byte.
    always_comb begin
        dpos = {1'b0, r_item.position};
        if ((r_item.func == FUNC_PAIR) && r_sub[0]) begin
            dpos = dpos + 5'd1;
        end
        if (r_item.func == FUNC_PAIR) begin
            num = r_sub[0] ? {4'b0000, ones_full[3:0]} : {3'b000, r_tens};
        end else begin
            num = r_item.value;
        end
        dsel = (num < 8'd10) ? num[3:0] : 4'd11;
        if (dpos <= 5'd3) begin
            seg  = seg_a(dsel);
            keep = 8'h10;
        end else if ((dpos == 5'd6) || (dpos == 5'd7)) begin
            seg  = seg_b(dsel);
            keep = 8'h08;
        end else begin
            seg  = seg_c(dsel);
            keep = 8'h80;
        end

        if (r_item.func == FUNC_FAN) begin
            ik  = fan_icon(r_sub[1:0]);
            iop = (r_item.value == {5'b00000, r_sub}) ? ICOP_SET : ICOP_CLR;
        end else begin
            ik = (r_item.icon == ICON_ALL) ? r_sub : r_item.icon;
            case (r_item.func)
                FUNC_ICON_ON:  iop = ICOP_SET;
                FUNC_ICON_OFF: iop = ICOP_CLR;
                default:       iop = ICOP_TOG;
            endcase
        end
        imask = icon_mask(ik);

        if (is_dig) begin
            slot     = digit_slot(dpos[3:0]);
            wr_ok    = (dpos <= 5'd8);
            new_byte = seg | (rd_eff & keep);
        end else begin
            slot  = icon_slot(ik);
            wr_ok = 1'b1;
            case (iop)
                ICOP_SET: new_byte = rd_eff | imask;
                ICOP_CLR: new_byte = rd_eff & ~imask;
                default:  new_byte = rd_eff ^ imask;
            endcase
        end

        case (r_item.func)
            FUNC_PAIR: op_last = 3'd1;
            FUNC_FAN:  op_last = 3'd2;
            FUNC_ICON_ON, FUNC_ICON_OFF, FUNC_ICON_TOG:
                op_last = (r_item.icon == ICON_ALL) ? 3'd6 : 3'd0;
            default:   op_last = 3'd0;
        endcase
    end

    assign addr = is_emit ? r_step[IMG_AW-1:0] : slot;

    // Byte of the current output step. Init is a two-byte head followed by
    // a clear-panel run.
    always_comb begin
        eff_step = r_step;
        if ((r_item.func == FUNC_INIT) && (r_step >= STEP_INIT_HEAD)) begin
            eff_step = r_step - STEP_INIT_HEAD;
        end
        fill      = (r_item.func == FUNC_SET) ? BYTE_FULL : BYTE_BLANK;
        emit_item = '0;
        if ((r_item.func == FUNC_INIT) && (r_step < STEP_INIT_HEAD)) begin
            emit_item.spi_byte   = (r_step == 5'd0) ? BYTE_MODE : BYTE_DISP_ON;
            emit_item.strobe_end = 1'b1;
        end else if (eff_step == 5'd0) begin
            emit_item.spi_byte   = BYTE_DATA_CMD;
            emit_item.strobe_end = 1'b1;
        end else if (eff_step == 5'd1) begin
            emit_item.spi_byte = (r_item.func == FUNC_FLUSH) ? BYTE_ADDR_FLUSH
                                                            : BYTE_ADDR_FILL;
        end else if (r_item.func == FUNC_FLUSH) begin
            emit_item.spi_byte   = rd_eff;
            emit_item.strobe_end = (eff_step == STEP_FLUSH_LAST);
        end else begin
            emit_item.spi_byte   = fill;
            emit_item.strobe_end = (eff_step == STEP_FILL_LAST);
        end
        case (r_item.func)
            FUNC_FLUSH: emit_item.last = (r_step == STEP_FLUSH_LAST);
            FUNC_INIT:  emit_item.last = (r_step == STEP_INIT_LAST);
            default:    emit_item.last = (r_step == STEP_FILL_LAST);
        endcase
    end

    always_comb begin
        n_item      = r_item;
        n_tens      = r_tens;
        n_sub       = r_sub;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (i_cmd.load) begin
            n_item = i_in_item;
            n_tens = tens_prod[15:11];
            n_sub  = '0;
            n_step = '0;
        end
        if (i_cmd.next_op) begin
            n_sub = r_sub + 3'd1;
        end
        if (i_cmd.next_step) begin
            n_step = r_step + 5'd1;
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_item  = emit_item;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sub       <= '0;
            r_step      <= '0;
            r_vld       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sub       <= n_sub;
            r_step      <= n_step;
            if (i_cmd.wr_en && wr_ok) begin
                r_vld[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_tens     <= n_tens;
        r_out_item <= n_out_item;
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[addr];
            r_rd_vld  <= r_vld[addr];
        end
        if (i_cmd.wr_en && wr_ok) begin
            r_mem[addr] <= new_byte;
        end
    end

    assign o_stat.in_cls    = cmd_class(i_in_item.func);
    assign o_stat.last_op   = (r_sub == op_last);
    assign o_stat.last_byte = emit_item.last;
    assign o_stat.out_room  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

### design/segment_lcd_frame_buffer_serializer_core.sv
// Segment LCD frame buffer with serial byte output.
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one command per
// transfer. Digit, pair, icon and fan commands update the 16-byte segment
// image and produce no output. Flush, clear-panel, set-panel and init
// commands produce a run of bytes on the output channel (o_out_valid /
// i_out_ready / o_out_item), the final byte of each run flagged by last.
// Timing: one command is worked on at a time. An image update reads, then
// writes, each byte that it touches. Each output byte is first read from
// the single-port image store into a register and then placed in the
// output register, one byte at a time.
// The next command is taken as soon as the final byte sits in the output
// register. When the receiver stalls, the pending byte holds and the run
// pauses. Reset empties the output register, returns the controller to
// idle and makes the whole image read as zero.
`default_nettype none
module segment_lcd_frame_buffer_serializer_core import slcd_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    slcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    slcd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

### design/slcd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module slcd_checker import slcd_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // High when the next output byte opens a new run.
    logic r_run_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_start <= 1'b1;
        end else if (o_out_valid && i_out_ready) begin
            r_run_start <= o_out_item.last;
        end
    end

    `AST_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "output dropped")
    `AST_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_item), "output changed")
    `AST_IMPL(a_last_strobe, o_out_valid && o_out_item.last, o_out_item.strobe_end, "no strobe release on last byte")
    `AST_IMPL(a_run_head, o_out_valid && r_run_start, (o_out_item.spi_byte == BYTE_DATA_CMD) || (o_out_item.spi_byte == BYTE_MODE), "run opens with wrong byte")

endmodule

bind segment_lcd_frame_buffer_serializer_core slcd_checker u_slcd_checker (.*);
`default_nettype wire
